[rtl/jdc_pkg.sv]
// Shared types, codes and constants for the joystick drive conditioner.
package jdc_pkg;

  localparam int unsigned AXIS_W   = 16;
  localparam int unsigned MAG_W    = 15;
  localparam int unsigned RAW_W    = 8;
  localparam int unsigned BTN_W    = 7;
  localparam int unsigned ANGLE_W  = 8;
  localparam int unsigned DELAY_W  = 16;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 16;

  localparam logic [MAG_W-1:0] Q14_ONE = 15'd16384;

  localparam logic [MAG_W-1:0]   DEADZONE_RST     = 15'd1638;
  localparam logic [MAG_W-1:0]   SLOW_LIMIT_RST   = 15'd4915;
  localparam logic [MAG_W-1:0]   FAST_LIMIT_RST   = 15'd16384;
  localparam logic [MAG_W-1:0]   NORMAL_LIMIT_RST = 15'd9830;
  localparam logic [MAG_W-1:0]   RAMP_STEP_RST    = 15'd819;
  localparam logic [DELAY_W-1:0] RELOAD_DELAY_RST = 16'd450;

  localparam logic [ANGLE_W-1:0] OUTTAKE_UP_DEG   = 8'd120;
  localparam logic [ANGLE_W-1:0] OUTTAKE_DOWN_DEG = 8'd85;
  localparam logic [ANGLE_W-1:0] RELOAD_FIRE_DEG  = 8'd90;
  localparam logic [ANGLE_W-1:0] RELOAD_REST_DEG  = 8'd175;
  localparam logic [ANGLE_W-1:0] HANDLE_OPEN_DEG  = 8'd90;
  localparam logic [ANGLE_W-1:0] HANDLE_SHUT_DEG  = 8'd180;

  localparam int unsigned BTN_L1    = 0;
  localparam int unsigned BTN_R1    = 1;
  localparam int unsigned BTN_L2    = 2;
  localparam int unsigned BTN_R2    = 3;
  localparam int unsigned BTN_DOWN  = 4;
  localparam int unsigned BTN_BLUE  = 5;
  localparam int unsigned BTN_GREEN = 6;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_DEADZONE     = 3'd0,
    REG_SLOW_LIMIT   = 3'd1,
    REG_FAST_LIMIT   = 3'd2,
    REG_NORMAL_LIMIT = 3'd3,
    REG_RAMP_STEP    = 3'd4,
    REG_RELOAD_DELAY = 3'd5
  } cfg_reg_t;

  typedef enum logic [1:0] {
    INTAKE_NONE    = 2'd0,
    INTAKE_RUN     = 2'd1,
    INTAKE_STOP    = 2'd2,
    INTAKE_REVERSE = 2'd3
  } intake_cmd_t;

  typedef struct packed {
    intake_cmd_t intake_cmd;
    logic        outtake_raised;
    logic        reload_active;
    logic        handle_open;
  } ctrl_t;

  typedef struct packed {
    logic signed [AXIS_W-1:0]  drive_forward;
    logic signed [AXIS_W-1:0]  drive_turn;
    intake_cmd_t               intake_cmd;
    logic        [ANGLE_W-1:0] outtake_angle;
    logic        [ANGLE_W-1:0] reload_angle;
    logic        [ANGLE_W-1:0] handle_angle;
  } res_t;

endpackage

[rtl/jdc_if.sv]
// Channel interfaces: input items, result items and configuration writes.
interface jdc_in_if
  import jdc_pkg::*;
  ();
  logic               valid;
  logic               ready;
  logic               command;
  logic               connected;
  logic [RAW_W-1:0]   forward_raw;
  logic [RAW_W-1:0]   turn_raw;
  logic [BTN_W-1:0]   buttons_held;

  modport source(output valid, command, connected, forward_raw, turn_raw, buttons_held,
                 input ready);
  modport sink(input valid, command, connected, forward_raw, turn_raw, buttons_held,
               output ready);
endinterface

interface jdc_out_if
  import jdc_pkg::*;
  ();
  logic                      valid;
  logic                      ready;
  logic signed [AXIS_W-1:0]  drive_forward;
  logic signed [AXIS_W-1:0]  drive_turn;
  logic [1:0]                intake_cmd;
  logic [ANGLE_W-1:0]        outtake_angle;
  logic [ANGLE_W-1:0]        reload_angle;
  logic [ANGLE_W-1:0]        handle_angle;

  modport source(output valid, drive_forward, drive_turn, intake_cmd, outtake_angle,
                 reload_angle, handle_angle, input ready);
  modport sink(input valid, drive_forward, drive_turn, intake_cmd, outtake_angle,
               reload_angle, handle_angle, output ready);
endinterface

interface jdc_cfg_if
  import jdc_pkg::*;
  ();
  logic                  valid;
  logic                  ready;
  logic [CFG_IDX_W-1:0]  index;
  logic [CFG_DATA_W-1:0] data;

  modport source(output valid, index, data, input ready);
  modport sink(input valid, index, data, output ready);
endinterface

[rtl/jdc_axis_lane.sv]
// One stick axis: center, scale to Q.14, deadzone, clamp and ramp the drive level.
module jdc_axis_lane
  import jdc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      accept,
  input  logic                      is_poll,
  input  logic                      connected,
  input  logic [RAW_W-1:0]          raw,
  input  logic [MAG_W-1:0]          limit,
  input  logic [MAG_W-1:0]          deadzone,
  input  logic [MAG_W-1:0]          ramp_step,
  output logic signed [AXIS_W-1:0]  level
);

  logic signed [AXIS_W-1:0] level_r;
  logic signed [AXIS_W-1:0] level_nxt;

  logic [RAW_W-1:0]   mag;
  logic               neg;
  logic [MAG_W-1:0]   q;
  logic [MAG_W-1:0]   q_dz;
  logic [MAG_W-1:0]   lim;
  logic [MAG_W-1:0]   q_cl;
  logic signed [AXIS_W+1:0] cur;
  logic signed [AXIS_W+1:0] tgt;
  logic signed [AXIS_W+1:0] step;
  logic signed [AXIS_W+1:0] up;
  logic signed [AXIS_W+1:0] dn;
  logic signed [AXIS_W+1:0] ramped;

  always_comb begin
    neg  = ~raw[RAW_W-1];
    mag  = raw[RAW_W-1] ? {1'b0, raw[RAW_W-2:0]} : (8'd128 - raw);
    q    = MAG_W'(mag) * 15'd129 + MAG_W'(mag[7] | mag[6]);
    q_dz = (q < deadzone) ? '0 : q;
    lim  = (limit > Q14_ONE) ? Q14_ONE : limit;
    q_cl = (q_dz > lim) ? lim : q_dz;
    if (!connected) begin
      tgt = '0;
    end else if (neg) begin
      tgt = -$signed({3'b000, q_cl});
    end else begin
      tgt = $signed({3'b000, q_cl});
    end
    cur  = $signed({{2{level_r[AXIS_W-1]}}, level_r});
    step = $signed({3'b000, ramp_step});
    up   = cur + step;
    dn   = cur - step;
    if (cur < tgt) begin
      ramped = (up > tgt) ? tgt : up;
    end else if (cur > tgt) begin
      ramped = (dn < tgt) ? tgt : dn;
    end else begin
      ramped = cur;
    end
    level     = is_poll ? ramped[AXIS_W-1:0] : level_r;
    level_nxt = (accept && is_poll) ? ramped[AXIS_W-1:0] : level_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      level_r <= '0;
    end else begin
      level_r <= level_nxt;
    end
  end

  a_level_range: assert property (@(posedge clk) disable iff (!rst_n)
    (level_r <= 16'sd16384) && (level_r >= -16'sd16384))
    else $error("drive level out of Q.14 range");

endmodule

[rtl/jdc_ctrl.sv]
// Button edges, intake command, servo flags and reload timer.
module jdc_ctrl
  import jdc_pkg::*;
(
  input  logic                clk,
  input  logic                rst_n,
  input  logic                accept,
  input  logic                command,
  input  logic                connected,
  input  logic [BTN_W-1:0]    buttons_held,
  input  logic [DELAY_W-1:0]  reload_delay,
  output ctrl_t               ctrl
);

  logic               intake_on_r, intake_on_nxt;
  logic               handle_open_r, handle_open_nxt;
  logic               outtake_r, outtake_nxt;
  logic               reload_active_r, reload_active_nxt;
  logic [DELAY_W-1:0] elapsed_r, elapsed_nxt;
  logic [BTN_W-1:0]   prev_r, prev_nxt;
  logic [BTN_W-1:0]   pressed;
  logic [BTN_W-1:0]   released;
  logic [DELAY_W-1:0] elapsed_inc;
  intake_cmd_t        cmd;

  always_comb begin
    intake_on_nxt     = intake_on_r;
    handle_open_nxt   = handle_open_r;
    outtake_nxt       = outtake_r;
    reload_active_nxt = reload_active_r;
    elapsed_nxt       = elapsed_r;
    prev_nxt          = prev_r;
    cmd               = INTAKE_NONE;
    pressed           = buttons_held & ~prev_r;
    released          = ~buttons_held & prev_r;
    elapsed_inc       = (elapsed_r != '1) ? elapsed_r + 16'd1 : elapsed_r;
    if (accept) begin
      if (!command) begin
        if (reload_active_r) begin
          elapsed_nxt = elapsed_inc;
          if (elapsed_inc >= reload_delay) begin
            reload_active_nxt = 1'b0;
          end
        end
      end else if (!connected) begin
        intake_on_nxt = 1'b0;
        cmd           = INTAKE_STOP;
      end else begin
        if (pressed[BTN_L2]) begin
          intake_on_nxt = ~intake_on_r;
          cmd           = intake_on_nxt ? INTAKE_RUN : INTAKE_STOP;
        end
        if (buttons_held[BTN_DOWN]) begin
          cmd = INTAKE_REVERSE;
        end else if (released[BTN_DOWN] && !intake_on_nxt) begin
          cmd = INTAKE_STOP;
        end
        outtake_nxt = buttons_held[BTN_R2];
        if (pressed[BTN_BLUE] && !reload_active_r) begin
          reload_active_nxt = 1'b1;
          elapsed_nxt       = '0;
        end
        if (pressed[BTN_GREEN]) begin
          handle_open_nxt = ~handle_open_r;
        end
        prev_nxt = buttons_held;
      end
    end
    ctrl.intake_cmd     = cmd;
    ctrl.outtake_raised = outtake_nxt;
    ctrl.reload_active  = reload_active_nxt;
    ctrl.handle_open    = handle_open_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      intake_on_r     <= 1'b0;
      handle_open_r   <= 1'b0;
      outtake_r       <= 1'b0;
      reload_active_r <= 1'b0;
      elapsed_r       <= '0;
      prev_r          <= '0;
    end else begin
      intake_on_r     <= intake_on_nxt;
      handle_open_r   <= handle_open_nxt;
      outtake_r       <= outtake_nxt;
      reload_active_r <= reload_active_nxt;
      elapsed_r       <= elapsed_nxt;
      prev_r          <= prev_nxt;
    end
  end

  a_reload_ends_on_tick: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $fell(reload_active_r) |-> $past(accept && !command))
    else $error("reload ended without a tick");

  a_reload_starts_on_poll: assert property (@(posedge clk) disable iff (!rst_n)
    $past(rst_n) && $rose(reload_active_r) |-> $past(accept && command && connected)
      && (elapsed_r == '0))
    else $error("reload started without a connected poll");

endmodule

[rtl/jdc_merge.sv]
// Merge lane levels and control flags into a result beat; output register plus skid entry.
module jdc_merge
  import jdc_pkg::*;
(
  input  logic                      clk,
  input  logic                      rst_n,
  input  logic                      load,
  input  logic signed [AXIS_W-1:0]  forward_level,
  input  logic signed [AXIS_W-1:0]  turn_level,
  input  ctrl_t                     ctrl,
  output logic                      in_ready,
  output logic                      out_valid,
  input  logic                      out_ready,
  output res_t                      out_res
);

  res_t res_new;
  res_t out_r, out_nxt;
  res_t skid_r, skid_nxt;
  logic out_valid_r, out_valid_nxt;
  logic skid_valid_r, skid_valid_nxt;
  logic take;

  always_comb begin
    res_new.drive_forward = forward_level;
    res_new.drive_turn    = turn_level;
    res_new.intake_cmd    = ctrl.intake_cmd;
    res_new.outtake_angle = ctrl.outtake_raised ? OUTTAKE_UP_DEG : OUTTAKE_DOWN_DEG;
    res_new.reload_angle  = ctrl.reload_active ? RELOAD_FIRE_DEG : RELOAD_REST_DEG;
    res_new.handle_angle  = ctrl.handle_open ? HANDLE_OPEN_DEG : HANDLE_SHUT_DEG;

    take           = out_valid_r && out_ready;
    out_nxt        = out_r;
    skid_nxt       = skid_r;
    out_valid_nxt  = out_valid_r;
    skid_valid_nxt = skid_valid_r;
    if (take) begin
      if (skid_valid_r) begin
        out_nxt        = skid_r;
        skid_valid_nxt = 1'b0;
      end else if (load) begin
        out_nxt = res_new;
      end else begin
        out_valid_nxt = 1'b0;
      end
    end else if (load) begin
      if (!out_valid_r) begin
        out_nxt       = res_new;
        out_valid_nxt = 1'b1;
      end else begin
        skid_nxt       = res_new;
        skid_valid_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    out_r  <= out_nxt;
    skid_r <= skid_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r  <= 1'b0;
      skid_valid_r <= 1'b0;
    end else begin
      out_valid_r  <= out_valid_nxt;
      skid_valid_r <= skid_valid_nxt;
    end
  end

  assign in_ready  = ~skid_valid_r;
  assign out_valid = out_valid_r;
  assign out_res   = out_r;

  a_skid_behind_out: assert property (@(posedge clk) disable iff (!rst_n)
    skid_valid_r |-> out_valid_r)
    else $error("skid entry held with empty output register");

  a_no_drop: assert property (@(posedge clk) disable iff (!rst_n)
    load && out_valid_r && !out_ready |=> skid_valid_r)
    else $error("result beat dropped while output stalled");

endmodule

[rtl/joystick_drive_conditioner.sv]
// Joystick drive conditioner: one result beat for every tick or poll beat.
// The result is registered in the output register, or in the skid entry while the output stalls.
// Throughput: one item per cycle; a one-entry skid stage keeps input ready for one
// beat while the output stalls, so ready drops only with both entries full.
// Reset (rst_n low at a clock edge): config registers to defaults, drive levels and flags zero; result data not reset.
module joystick_drive_conditioner
  import jdc_pkg::*;
(
  input  logic clk,
  input  logic rst_n,
  jdc_in_if.sink    in_ch,
  jdc_out_if.source out_ch,
  jdc_cfg_if.sink   cfg_ch
);

  logic [MAG_W-1:0]   deadzone_r;
  logic [MAG_W-1:0]   slow_limit_r;
  logic [MAG_W-1:0]   fast_limit_r;
  logic [MAG_W-1:0]   normal_limit_r;
  logic [MAG_W-1:0]   ramp_step_r;
  logic [DELAY_W-1:0] reload_delay_r;

  logic                     accept;
  logic                     in_ready;
  logic [MAG_W-1:0]         limit;
  logic signed [AXIS_W-1:0] forward_level;
  logic signed [AXIS_W-1:0] turn_level;
  ctrl_t                    ctrl;
  res_t                     out_res;

  assign cfg_ch.ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      deadzone_r     <= DEADZONE_RST;
      slow_limit_r   <= SLOW_LIMIT_RST;
      fast_limit_r   <= FAST_LIMIT_RST;
      normal_limit_r <= NORMAL_LIMIT_RST;
      ramp_step_r    <= RAMP_STEP_RST;
      reload_delay_r <= RELOAD_DELAY_RST;
    end else if (cfg_ch.valid) begin
      unique case (cfg_reg_t'(cfg_ch.index))
        REG_DEADZONE:     deadzone_r     <= cfg_ch.data[MAG_W-1:0];
        REG_SLOW_LIMIT:   slow_limit_r   <= cfg_ch.data[MAG_W-1:0];
        REG_FAST_LIMIT:   fast_limit_r   <= cfg_ch.data[MAG_W-1:0];
        REG_NORMAL_LIMIT: normal_limit_r <= cfg_ch.data[MAG_W-1:0];
        REG_RAMP_STEP:    ramp_step_r    <= cfg_ch.data[MAG_W-1:0];
        REG_RELOAD_DELAY: reload_delay_r <= cfg_ch.data;
        default: begin
        end
      endcase
    end
  end

  assign accept      = in_ch.valid && in_ready;
  assign in_ch.ready = in_ready;

  always_comb begin
    priority if (in_ch.buttons_held[BTN_L1]) begin
      limit = slow_limit_r;
    end else if (in_ch.buttons_held[BTN_R1]) begin
      limit = fast_limit_r;
    end else begin
      limit = normal_limit_r;
    end
  end

  jdc_axis_lane u_lane_forward (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .is_poll   (in_ch.command),
    .connected (in_ch.connected),
    .raw       (in_ch.forward_raw),
    .limit     (limit),
    .deadzone  (deadzone_r),
    .ramp_step (ramp_step_r),
    .level     (forward_level)
  );

  jdc_axis_lane u_lane_turn (
    .clk       (clk),
    .rst_n     (rst_n),
    .accept    (accept),
    .is_poll   (in_ch.command),
    .connected (in_ch.connected),
    .raw       (in_ch.turn_raw),
    .limit     (limit),
    .deadzone  (deadzone_r),
    .ramp_step (ramp_step_r),
    .level     (turn_level)
  );

  jdc_ctrl u_ctrl (
    .clk          (clk),
    .rst_n        (rst_n),
    .accept       (accept),
    .command      (in_ch.command),
    .connected    (in_ch.connected),
    .buttons_held (in_ch.buttons_held),
    .reload_delay (reload_delay_r),
    .ctrl         (ctrl)
  );

  jdc_merge u_merge (
    .clk           (clk),
    .rst_n         (rst_n),
    .load          (accept),
    .forward_level (forward_level),
    .turn_level    (turn_level),
    .ctrl          (ctrl),
    .in_ready      (in_ready),
    .out_valid     (out_ch.valid),
    .out_ready     (out_ch.ready),
    .out_res       (out_res)
  );

  assign out_ch.drive_forward = out_res.drive_forward;
  assign out_ch.drive_turn    = out_res.drive_turn;
  assign out_ch.intake_cmd    = out_res.intake_cmd;
  assign out_ch.outtake_angle = out_res.outtake_angle;
  assign out_ch.reload_angle  = out_res.reload_angle;
  assign out_ch.handle_angle  = out_res.handle_angle;

endmodule
